>>> sv/ttrr_pkg.sv
// Package: shared types, constants and codes of the task table scheduler.
`default_nettype none
package ttrr_pkg;
  localparam int TASK_SLOTS = 64;
  localparam int CPU_COUNT  = 8;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SCHED  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_SET    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  cpu_id;
    logic [31:0] pid_query;
    logic [5:0]  slot_sel;
    logic        set_in_use;
    logic        set_active;
    logic [31:0] sleep_until;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] pid_out;
    logic [31:0] parent_out;
  } out_item_t;

  // One table entry: flags, ids and deadline.
  typedef struct packed {
    logic        in_use;
    logic        active;
    logic        running;
    logic [31:0] pid;
    logic [31:0] parent;
    logic [31:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

>>> sv/ttrr_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ttrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> sv/task_table_round_robin_scheduler.sv
// Top level: task table with a per-processor round-robin scheduler.
//
// One item is in work at a time. The table sits in one single-port RAM
// (one entry per slot); the flag bits in_use, active and running are kept in
// flip-flops, so reset clears them at once and no clearing pass is needed.
// Add finds the lowest free slot from the flag bits while the RAM reads the
// processor's current slot for the parent id, then writes the new entry
// (states S_RD, S_PAR, S_WR, S_OUT). Set reads the slot and writes it back
// through the same states; a full table is answered from S_RD alone.
// Lookup examines one slot at a time (present the address, then compare the
// read data), starting at slot 0. Schedule releases the current slot, then
// walks one slot at a time from the slot after it, with wrap-around. The
// result waits in an output register; in_stall is high while an item is in
// work or a result is not yet taken, and the next transfer can be accepted
// in the cycle after a result is taken.
`default_nettype none
module task_table_round_robin_scheduler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ttrr_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ttrr_pkg::out_item_t     out_data
);
  localparam int SW = ttrr_pkg::SLOT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,  // address presented, wait for read data
    S_SCAN  = 7'b0000100,  // examine read data, advance
    S_PAR   = 7'b0001000,  // add: parent read data valid; set: slot read data valid; scans: wait for read
    S_WR    = 7'b0010000,  // write entry back
    S_OUT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r;
  ttrr_pkg::in_item_t item_r;

  logic [ttrr_pkg::TASK_SLOTS-1:0] in_use_r, active_r, running_r;
  logic [31:0]                     last_pid_r;
  logic [SW-1:0]                   cur_r [ttrr_pkg::CPU_COUNT];
  logic [SW-1:0]                   addr_r;      // slot being read
  logic [SW-1:0]                   tgt_r;       // slot to write / answer
  logic [ttrr_pkg::CNT_W-1:0]      cnt_r;       // slots examined
  ttrr_pkg::out_item_t             res_r;
  logic                            ovalid_r;

  logic                  ram_we;
  logic [SW-1:0]         ram_addr;
  ttrr_pkg::entry_t      ram_wdata, ram_rdata;
  logic [ttrr_pkg::ENTRY_W-1:0] rd_raw;

  assign ram_rdata = ttrr_pkg::entry_t'(rd_raw);

  ttrr_ram #(.WIDTH(ttrr_pkg::ENTRY_W), .DEPTH(ttrr_pkg::TASK_SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd_raw)
  );

  // Processor index modulo CPU_COUNT.
  logic [ttrr_pkg::CPU_W-1:0] cpu;
  always_comb begin
    cpu = ttrr_pkg::CPU_W'(32'(item_r.cpu_id) % ttrr_pkg::CPU_COUNT);
  end
  logic [SW-1:0] cur;
  assign cur = cur_r[cpu];

  // Processor of the incoming transfer, so add can read its current slot early.
  logic [ttrr_pkg::CPU_W-1:0] in_cpu;
  always_comb begin
    in_cpu = ttrr_pkg::CPU_W'(32'(in_data.cpu_id) % ttrr_pkg::CPU_COUNT);
  end

  // Lowest free slot.
  logic          free_found;
  logic [SW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = ttrr_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  logic sel_ok;
  assign sel_ok = 32'(item_r.slot_sel) < ttrr_pkg::TASK_SLOTS;

  logic [SW-1:0] addr_inc;
  assign addr_inc = (32'(addr_r) == ttrr_pkg::TASK_SLOTS - 1) ? '0 : addr_r + 1'b1;

  logic hit;
  always_comb begin
    hit = 1'b0;
    if (item_r.op == ttrr_pkg::OP_LOOKUP) begin
      hit = in_use_r[addr_r] && (ram_rdata.pid == item_r.pid_query);
    end else begin
      hit = in_use_r[addr_r] && active_r[addr_r] && !running_r[addr_r]
            && (ram_rdata.deadline <= item_r.time_now);
    end
  end

  logic last_scan;
  assign last_scan = 32'(cnt_r) == ttrr_pkg::TASK_SLOTS - 1;

  // RAM port: read at addr_r, except for the write-back cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = ram_rdata;
    if (state_r == S_WR) begin
      ram_we   = 1'b1;
      ram_addr = tgt_r;
      if (item_r.op == ttrr_pkg::OP_ADD) begin
        ram_wdata.pid    = last_pid_r;
        ram_wdata.parent = res_r.parent_out;
      end else begin
        ram_wdata.deadline = item_r.sleep_until;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_use_r   <= '0;
      active_r   <= '0;
      running_r  <= '0;
      last_pid_r <= '0;
      ovalid_r   <= 1'b0;
      for (int c = 0; c < ttrr_pkg::CPU_COUNT; c++) cur_r[c] <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            cnt_r  <= '0;
            state_r <= S_RD;
            // Choose the first address to read for each operation.
            unique case (in_data.op)
              ttrr_pkg::OP_ADD:    addr_r <= cur_r[in_cpu];
              ttrr_pkg::OP_SCHED:  addr_r <= '0;
              ttrr_pkg::OP_LOOKUP: addr_r <= '0;
              ttrr_pkg::OP_SET:    addr_r <= in_data.slot_sel[SW-1:0];
              default:             addr_r <= '0;
            endcase
          end
        end
        S_RD: begin
          unique case (item_r.op)
            ttrr_pkg::OP_ADD: begin
              if (free_found) begin
                tgt_r   <= free_slot;
                state_r <= S_PAR;
              end else begin
                res_r   <= '{ttrr_pkg::ST_FULL, '0, '0, '0};
                state_r <= S_DONE;
                ovalid_r <= 1'b1;
              end
            end
            ttrr_pkg::OP_SCHED: begin
              // Release the current slot and start after it.
              running_r[cur] <= 1'b0;
              addr_r <= (32'(cur) == ttrr_pkg::TASK_SLOTS - 1) ? '0 : cur + 1'b1;
              state_r <= S_PAR;  // first read issued in S_PAR
              tgt_r <= cur;
            end
            ttrr_pkg::OP_SET: begin
              if (!sel_ok) begin
                res_r   <= '{ttrr_pkg::ST_NOTFOUND, '0, '0, '0};
                state_r <= S_DONE;
                ovalid_r <= 1'b1;
              end else begin
                tgt_r <= addr_r;
                state_r <= S_PAR;
              end
            end
            default: state_r <= S_SCAN;  // lookup: data for slot 0 arrives next cycle
          endcase
        end
        S_PAR: begin
          unique case (item_r.op)
            ttrr_pkg::OP_ADD: begin
              // Read data of the current slot has arrived. A new task placed
              // in the processor's own current slot becomes its own parent.
              in_use_r[tgt_r]  <= 1'b1;
              active_r[tgt_r]  <= 1'b0;
              running_r[tgt_r] <= 1'b0;
              last_pid_r <= last_pid_r + 1'b1;
              res_r <= '{ttrr_pkg::ST_OK, 6'(tgt_r), last_pid_r + 1'b1,
                         (tgt_r == addr_r) ? last_pid_r + 1'b1 :
                         (in_use_r[addr_r] ? ram_rdata.pid : 32'd0)};
              state_r <= S_WR;
            end
            ttrr_pkg::OP_SET: begin
              in_use_r[tgt_r] <= item_r.set_in_use;
              active_r[tgt_r] <= item_r.set_active;
              if (!item_r.set_in_use) running_r[tgt_r] <= 1'b0;
              res_r <= '{ttrr_pkg::ST_OK, 6'(tgt_r), ram_rdata.pid, ram_rdata.parent};
              state_r <= S_WR;
            end
            default: state_r <= S_SCAN;  // schedule: first read issued now
          endcase
        end
        S_SCAN: begin
          if (hit) begin
            res_r <= '{ttrr_pkg::ST_OK, 6'(addr_r), ram_rdata.pid, ram_rdata.parent};
            if (item_r.op == ttrr_pkg::OP_SCHED) begin
              running_r[addr_r] <= 1'b1;
              cur_r[cpu] <= addr_r;
            end
            ovalid_r <= 1'b1;
            state_r  <= S_DONE;
          end else if (last_scan) begin
            if (item_r.op == ttrr_pkg::OP_SCHED) begin
              res_r <= '{ttrr_pkg::ST_NONE, 6'(tgt_r), '0, '0};
            end else begin
              res_r <= '{ttrr_pkg::ST_NOTFOUND, '0, '0, '0};
            end
            ovalid_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            // Advance one slot; its read data arrives in S_SCAN after S_PAR.
            addr_r  <= addr_inc;
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_PAR;
          end
        end
        S_WR: state_r <= S_OUT;
        S_OUT: begin
          ovalid_r <= 1'b1;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_stall) begin
            ovalid_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;
endmodule
`default_nettype wire

>>> sv/ttrr_checker.sv
// Port-level checker for the task table scheduler, bound to the top level.
`default_nettype none
module ttrr_assertions (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ttrr_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result waits");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ttrr_pkg::ST_OK
    && out_data.status != ttrr_pkg::ST_NONE |-> out_data.slot_out == '0)
    else $error("failure result carries a slot");
endmodule

bind task_table_round_robin_scheduler ttrr_assertions u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

>>> sim/ttrr_checker.sv
// Checker: watches both channels, predicts task table results and compares.
`timescale 1ns / 100ps
`default_nettype none
module ttrr_checker
  import ttrr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             pending
);
  // Shadow of the task table and scheduler state.
  logic        sh_in_use  [TASK_SLOTS];
  logic        sh_active  [TASK_SLOTS];
  logic        sh_running [TASK_SLOTS];
  logic [31:0] sh_pid     [TASK_SLOTS];
  logic [31:0] sh_parent  [TASK_SLOTS];
  logic [31:0] sh_deadline[TASK_SLOTS];
  logic [31:0] sh_last_pid;
  logic [5:0]  sh_cur     [CPU_COUNT];

  out_item_t expected_results[$];

  function automatic out_item_t pack_result(logic [1:0] st, logic [5:0] slot,
                                            logic [31:0] pid, logic [31:0] par);
    out_item_t r;
    r.status = st; r.slot_out = slot; r.pid_out = pid; r.parent_out = par;
    return r;
  endfunction

  // Apply one operation to the shadow table and return its answer.
  function automatic out_item_t apply_op(in_item_t it);
    int          cpu;
    int          cur;
    int          e;
    logic [31:0] par;
    cpu = int'(it.cpu_id) % CPU_COUNT;
    cur = int'(sh_cur[cpu]) % TASK_SLOTS;
    case (it.op)
      OP_ADD: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!sh_in_use[i]) begin
            sh_in_use[i] = 1'b1; sh_active[i] = 1'b0; sh_running[i] = 1'b0;
            sh_last_pid = sh_last_pid + 32'd1;
            sh_pid[i] = sh_last_pid;
            // The new slot may be the processor's current one.
            par = sh_in_use[cur] ? sh_pid[cur] : 32'd0;
            sh_parent[i] = par;
            return pack_result(ST_OK, 6'(i), sh_pid[i], par);
          end
        end
        return pack_result(ST_FULL, '0, '0, '0);
      end
      OP_SCHED: begin
        sh_running[cur] = 1'b0;
        for (int k = 1; k <= TASK_SLOTS; k++) begin
          e = (cur + k) % TASK_SLOTS;
          if (sh_in_use[e] && sh_active[e] && !sh_running[e] &&
              sh_deadline[e] <= it.time_now) begin
            sh_running[e] = 1'b1;
            sh_cur[cpu] = 6'(e);
            return pack_result(ST_OK, 6'(e), sh_pid[e], sh_parent[e]);
          end
        end
        return pack_result(ST_NONE, 6'(cur), '0, '0);
      end
      OP_LOOKUP: begin
        for (int i = 0; i < TASK_SLOTS; i++)
          if (sh_in_use[i] && sh_pid[i] == it.pid_query)
            return pack_result(ST_OK, 6'(i), sh_pid[i], sh_parent[i]);
        return pack_result(ST_NOTFOUND, '0, '0, '0);
      end
      default: begin
        if (int'(it.slot_sel) >= TASK_SLOTS)
          return pack_result(ST_NOTFOUND, '0, '0, '0);
        sh_in_use[it.slot_sel]   = it.set_in_use;
        sh_active[it.slot_sel]   = it.set_active;
        sh_deadline[it.slot_sel] = it.sleep_until;
        if (!it.set_in_use) sh_running[it.slot_sel] = 1'b0;
        return pack_result(ST_OK, it.slot_sel, sh_pid[it.slot_sel],
                           sh_parent[it.slot_sel]);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        sh_in_use[i] = 1'b0; sh_active[i] = 1'b0; sh_running[i] = 1'b0;
        sh_pid[i] = '0; sh_parent[i] = '0; sh_deadline[i] = '0;
      end
      for (int c = 0; c < CPU_COUNT; c++) sh_cur[c] = '0;
      sh_last_pid = '0;
      expected_results.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      // Check the result first: a result can never belong to the item taken
      // at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, out_data.status);
            fail_count++;
          end
          if (out_data.slot_out !== want.slot_out) begin
            $display("%0t: slot exp %0d got %0d", $time, want.slot_out, out_data.slot_out);
            fail_count++;
          end
          if (out_data.pid_out !== want.pid_out) begin
            $display("%0t: pid exp %h got %h", $time, want.pid_out, out_data.pid_out);
            fail_count++;
          end
          if (out_data.parent_out !== want.parent_out) begin
            $display("%0t: parent exp %h got %h", $time, want.parent_out,
                     out_data.parent_out);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_op(in_data));
      pending = expected_results.size();
    end
  end
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the task scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ttrr_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  longint    cycle_count = 0;

  // Shadow of which slots the stimulus has allocated through add, so no set
  // ever touches a never-allocated slot (its ids are undefined).
  bit          allocated[TASK_SLOTS];
  logic [31:0] pid_seen[$];

  always #4 clk = ~clk;

  task_table_round_robin_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ttrr_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall pattern: alternate calm and busy stretches.
  always @(negedge clk) begin
    if ((cycle_count / 500) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 40);
  end

  // Hold one transfer until accepted, then drop valid only if a gap follows.
  task automatic send_item(input in_item_t it, input bit keep_valid);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!keep_valid) in_valid <= 1'b0;
  endtask

  // Build a random item; sets only target allocated slots.
  function automatic in_item_t make_item(int op_weight_sched);
    in_item_t it;
    int       r;
    it.cpu_id      = 3'($urandom);
    it.pid_query   = $urandom;
    it.slot_sel    = 6'($urandom);
    it.set_in_use  = 1'($urandom);
    it.set_active  = 1'($urandom);
    it.sleep_until = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    it.time_now    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    r = $urandom_range(0, 99);
    if (r < 25) it.op = OP_ADD;
    else if (r < 25 + op_weight_sched) it.op = OP_SCHED;
    else if (r < 45 + op_weight_sched) it.op = OP_LOOKUP;
    else it.op = OP_SET;
    if (it.op == OP_SET && !allocated[it.slot_sel])
      it.op = OP_LOOKUP;
    if (it.op == OP_LOOKUP && pid_seen.size() > 0 && $urandom_range(0, 2) != 0)
      it.pid_query = pid_seen[$urandom_range(0, pid_seen.size() - 1)];
    return it;
  endfunction

  // Mirror of the table's in-use state for stimulus shaping only.
  bit in_use_mirror[TASK_SLOTS];
  int next_pid = 1;

  function automatic void note_item(in_item_t it);
    if (it.op == OP_ADD) begin
      for (int i = 0; i < TASK_SLOTS; i++)
        if (!in_use_mirror[i]) begin
          in_use_mirror[i] = 1'b1;
          allocated[i] = 1'b1;
          pid_seen.push_back(32'(next_pid));
          next_pid++;
          break;
        end
    end else if (it.op == OP_SET) begin
      in_use_mirror[it.slot_sel] = it.set_in_use;
    end
  endfunction

  task automatic issue(input in_item_t it, input bit keep_valid);
    note_item(it);
    send_item(it, keep_valid);
  endtask

  in_item_t item;
  int       burst;
  int       sent;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table cases, then fill, full, activate and schedule.
    item = '0;
    item.op = OP_SCHED; item.cpu_id = 3'd7; issue(item, 0);
    item.op = OP_LOOKUP; item.pid_query = 32'hFFFF_FFFF; issue(item, 0);
    item.op = OP_ADD; item.cpu_id = 3'd0; issue(item, 0);
    item.op = OP_SET; item.slot_sel = 6'd0; item.set_in_use = 1'b1;
    item.set_active = 1'b1; item.sleep_until = 32'd0; issue(item, 0);
    item.op = OP_SCHED; item.cpu_id = 3'd0; item.time_now = 32'd0; issue(item, 0);
    item.op = OP_ADD; item.cpu_id = 3'd0; issue(item, 1);
    // Fill the table with back-to-back adds; the last one hits table full.
    for (int i = 0; i < 63; i++) begin
      item = '0; item.op = OP_ADD; item.cpu_id = 3'(i); issue(item, i < 62);
    end
    item.op = OP_LOOKUP; item.pid_query = 32'd2; issue(item, 0);
    // Sleeping task: deadline at the top of the range.
    item = '0; item.op = OP_SET; item.slot_sel = 6'd63; item.set_in_use = 1'b1;
    item.set_active = 1'b1; item.sleep_until = 32'hFFFF_FFFF; issue(item, 0);
    item = '0; item.op = OP_SCHED; item.cpu_id = 3'd0;
    item.time_now = 32'hFFFF_FFFE; issue(item, 0);
    item.time_now = 32'hFFFF_FFFF; issue(item, 0);
    item.cpu_id = 3'd5; issue(item, 0);
    // Free a running slot, then schedule wraps around and finds no ready slot.
    item = '0; item.op = OP_SET; item.slot_sel = 6'd63; issue(item, 0);
    item = '0; item.op = OP_SCHED; item.cpu_id = 3'd0; issue(item, 0);

    // Pause until every expected result has arrived.
    while (pending != 0) @(negedge clk);

    // Random part: bursts with gaps, schedule weighted up in the second half.
    sent = 0;
    while (sent < 800) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < 800; b++) begin
        item = make_item(sent < 400 ? 15 : 30);
        issue(item, (b < burst - 1) && (sent < 799));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
      if (sent == 400) while (pending != 0) @(negedge clk);
    end

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
